// ----- rtl/core/stpr_pkg.sv -----
// ---------------------------------------------------------------------------
// stpr_pkg: shared types, constants and helpers of the taper profile core
// Q1.30 number formats, configuration layout, pipeline mode codes and the
// rounded Q30 multiply used by the smoothstep stages.
// ---------------------------------------------------------------------------
package stpr_pkg;

    // Q1.30 values: one is 2^30, held in 31 bits
    localparam int Q30_W = 31;
    typedef logic [Q30_W-1:0] q30_t;

    localparam q30_t ONE_Q30  = 31'h4000_0000;
    localparam q30_t HALF_Q30 = 31'h2000_0000;

    // 1 - 0.33, Q30
    localparam q30_t CORNER_SLOPE = 31'd719407022;

    // Divider geometry
    localparam int XI_QW   = 30;   // quotient bits of the layer depth ratio
    localparam int XI_DW   = 31;   // taper width bits
    localparam int DAMP_QW = 32;   // quotient bits of the damping ratio
    localparam int DAMP_DW = 31;   // stretch bits

    // Power chain stages (t^2 .. t^11)
    localparam int POLY_STAGES = 10;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_ENABLE  = 3'd0,
        CFG_RIGHT_ENABLE = 3'd1,
        CFG_LEFT_START   = 3'd2,
        CFG_RIGHT_END    = 3'd3,
        CFG_TAPER_WIDTH  = 3'd4,
        CFG_MIN_STRETCH  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic        left_enable;
        logic        right_enable;
        logic [31:0] left_start;
        logic [31:0] right_end;
        logic [30:0] taper_width;
        logic [31:0] min_stretch;
    } cfg_t;

    localparam logic [31:0] RST_LEFT_START  = 32'd0;
    localparam logic [31:0] RST_RIGHT_END   = 32'd65536;
    localparam logic [30:0] RST_TAPER_WIDTH = 31'd6554;
    localparam logic [31:0] RST_MIN_STRETCH = 32'd429497;

    // How the layer depth is formed
    typedef enum logic [1:0] {
        XI_ZERO,
        XI_ONE,
        XI_DIV
    } xi_mode_t;

    // How the damping coefficient is formed
    typedef enum logic [1:0] {
        DAMP_ZERO,
        DAMP_MAX,
        DAMP_DIV
    } damp_mode_t;

    // Sideband carried through the damping divider
    typedef struct packed {
        damp_mode_t mode;
        q30_t       phi;
        q30_t       corner;
    } dside_t;

    // Power chain stage contents
    typedef struct packed {
        logic [11:0][Q30_W-1:0] tp;
        logic [5:0][Q30_W-1:0]  up;
    } pw_t;

    // Result word
    typedef struct packed {
        q30_t        stretch;
        logic [31:0] damping;
        q30_t        corner_weight;
    } out_word_t;

    // Q30 product, rounded half up; operands at most one
    function automatic q30_t mulq(q30_t a, q30_t b);
        logic [61:0] p;
        p = 62'(a) * 62'(b) + 62'(HALF_Q30);
        return p[60:30];
    endfunction

    // Binomial coefficients of order 11
    function automatic logic [8:0] binom11(int k);
        logic [8:0] c;
        case (k)
            0, 11:   c = 9'd1;
            1, 10:   c = 9'd11;
            2, 9:    c = 9'd55;
            3, 8:    c = 9'd165;
            4, 7:    c = 9'd330;
            5, 6:    c = 9'd462;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/stpr_layer.sv -----
// ---------------------------------------------------------------------------
// stpr_layer: taper layer selection
// Registers the coordinate, finds the layer it falls in and the distance
// into that layer, and classifies the depth as zero, one or a true ratio.
// ---------------------------------------------------------------------------
module stpr_layer
    import stpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_v,
    input  logic [31:0] position,
    input  cfg_t        cfg,
    output logic        out_v,
    output xi_mode_t    out_mode,
    output logic [30:0] out_num,
    output logic [30:0] out_width
);

    logic        v1_reg;
    logic [31:0] pos_reg;
    logic        v2_reg;
    xi_mode_t    mode_reg;
    logic [30:0] num_reg;
    logic [30:0] width_reg;

    logic signed [33:0] x, x0, x1, w;
    logic signed [33:0] lsum, rsub, num;
    logic               left_in, right_in;
    xi_mode_t           mode_next;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_v;
            v2_reg <= v1_reg;
        end
    end

    // Layer membership and distance into the layer
    always_comb
    begin
        x        = 34'(signed'(pos_reg));
        x0       = 34'(signed'(cfg.left_start));
        x1       = 34'(signed'(cfg.right_end));
        w        = signed'({3'b000, cfg.taper_width});
        lsum     = x0 + w;
        rsub     = x1 - w;
        left_in  = cfg.left_enable && (x < lsum);
        right_in = cfg.right_enable && (x > rsub);
        num      = left_in ? (lsum - x) : (x - rsub);
        if (!(left_in || right_in) || (num <= 34'sd0))
            mode_next = XI_ZERO;
        else if (num >= w)
            mode_next = XI_ONE;
        else
            mode_next = XI_DIV;
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg   <= position;
            mode_reg  <= mode_next;
            num_reg   <= num[30:0];
            width_reg <= cfg.taper_width;
        end
    end

    assign out_v     = v2_reg;
    assign out_mode  = mode_reg;
    assign out_num   = num_reg;
    assign out_width = width_reg;

endmodule

// ----- rtl/core/stpr_div.sv -----
// ---------------------------------------------------------------------------
// stpr_div: pipelined restoring divider with a sideband travelling alongside
// One quotient bit per stage. The caller must start the partial remainder below
// the divisor (not enforced here); low numerator bits shift in one per stage.
// ---------------------------------------------------------------------------
module stpr_div #(
    parameter int QW = 30,
    parameter int DW = 31,
    parameter int SW = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_v,
    input  logic [DW-1:0] in_rem,
    input  logic [QW-1:0] in_low,
    input  logic [DW-1:0] in_div,
    input  logic [SW-1:0] in_side,
    output logic          out_v,
    output logic [QW-1:0] out_quo,
    output logic [SW-1:0] out_side
);

    logic [QW-1:0] v_reg;
    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] low_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [DW-1:0] div_reg  [QW];
    logic [SW-1:0] side_reg [QW];

    logic [DW-1:0] rem_cur  [QW];
    logic [QW-1:0] low_cur  [QW];
    logic [QW-1:0] quo_cur  [QW];
    logic [DW-1:0] div_cur  [QW];
    logic [SW-1:0] side_cur [QW];

    logic [DW:0]   shifted  [QW];
    logic [DW:0]   diff     [QW];
    logic [QW-1:0] ge;
    logic [DW-1:0] rem_next [QW];

    // Stage inputs: port for the first, previous register for the rest
    always_comb
    begin
        rem_cur[0]  = in_rem;
        low_cur[0]  = in_low;
        quo_cur[0]  = '0;
        div_cur[0]  = in_div;
        side_cur[0] = in_side;
        for (int i = 1; i < QW; i++)
        begin
            rem_cur[i]  = rem_reg[i-1];
            low_cur[i]  = low_reg[i-1];
            quo_cur[i]  = quo_reg[i-1];
            div_cur[i]  = div_reg[i-1];
            side_cur[i] = side_reg[i-1];
        end
    end

    // Trial subtract in every stage
    always_comb
    begin
        for (int i = 0; i < QW; i++)
        begin
            shifted[i]  = {rem_cur[i], low_cur[i][QW-1]};
            diff[i]     = shifted[i] - {1'b0, div_cur[i]};
            ge[i]       = shifted[i] >= {1'b0, div_cur[i]};
            rem_next[i] = ge[i] ? diff[i][DW-1:0] : shifted[i][DW-1:0];
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[QW-2:0], in_v};
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < QW; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                low_reg[i]  <= {low_cur[i][QW-2:0], 1'b0};
                quo_reg[i]  <= {quo_cur[i][QW-2:0], ge[i]};
                div_reg[i]  <= div_cur[i];
                side_reg[i] <= side_cur[i];
            end
        end
    end

    assign out_v    = v_reg[QW-1];
    assign out_quo  = quo_reg[QW-1];
    assign out_side = side_reg[QW-1];

endmodule

// ----- rtl/core/stpr_poly.sv -----
// ---------------------------------------------------------------------------
// stpr_poly: C5 smoothstep in Bernstein form
// Builds t^2..t^11 (one per stage) and u^2..u^5 (alongside) by rounded multiplies,
// forms the six Bernstein products, then weights, sums and clamps them to one.
// ---------------------------------------------------------------------------
module stpr_poly
    import stpr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_v,
    input  q30_t in_t,
    output logic out_v,
    output q30_t out_sigma,
    output q30_t out_xi
);

    logic [POLY_STAGES-1:0] pw_v_reg;
    pw_t                    pw_reg  [POLY_STAGES];
    pw_t                    pw_cur  [POLY_STAGES];
    pw_t                    pw_next [POLY_STAGES];

    logic                   prod_v_reg;
    logic [5:0][Q30_W-1:0]  prod_reg;
    logic [5:0][Q30_W-1:0]  prod_next;
    q30_t                   prod_xi_reg;

    logic                   sum_v_reg;
    q30_t                   sigma_reg;
    q30_t                   sum_xi_reg;
    logic [41:0]            sum;
    q30_t                   sigma_next;

    // Seed the power chain
    always_comb
    begin
        pw_cur[0]       = '0;
        pw_cur[0].tp[0] = ONE_Q30;
        pw_cur[0].tp[1] = in_t;
        pw_cur[0].up[0] = ONE_Q30;
        pw_cur[0].up[1] = ONE_Q30 - in_t;
        for (int i = 1; i < POLY_STAGES; i++)
            pw_cur[i] = pw_reg[i-1];
    end

    // One more power of t, and of u while it is still needed
    always_comb
    begin
        for (int i = 0; i < POLY_STAGES; i++)
        begin
            pw_next[i]         = pw_cur[i];
            pw_next[i].tp[i+2] = mulq(pw_cur[i].tp[i+1], pw_cur[i].tp[1]);
            if (i + 2 <= 5)
                pw_next[i].up[i+2] = mulq(pw_cur[i].up[i+1], pw_cur[i].up[1]);
        end
    end

    // Bernstein products t^k * u^(11-k), k = 6..11
    always_comb
    begin
        for (int j = 0; j < 6; j++)
            prod_next[j] = mulq(pw_reg[POLY_STAGES-1].tp[6+j],
                                pw_reg[POLY_STAGES-1].up[5-j]);
    end

    // Weight, sum and clamp
    always_comb
    begin
        sum = '0;
        for (int j = 0; j < 6; j++)
            sum = sum + 42'(binom11(6 + j)) * 42'(prod_reg[j]);
        sigma_next = (sum > 42'(ONE_Q30)) ? ONE_Q30 : sum[Q30_W-1:0];
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_v_reg   <= '0;
            prod_v_reg <= 1'b0;
            sum_v_reg  <= 1'b0;
        end
        else if (en)
        begin
            pw_v_reg   <= {pw_v_reg[POLY_STAGES-2:0], in_v};
            prod_v_reg <= pw_v_reg[POLY_STAGES-1];
            sum_v_reg  <= prod_v_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < POLY_STAGES; i++)
                pw_reg[i] <= pw_next[i];
            prod_reg    <= prod_next;
            prod_xi_reg <= pw_reg[POLY_STAGES-1].tp[1];
            sigma_reg   <= sigma_next;
            sum_xi_reg  <= prod_xi_reg;
        end
    end

    assign out_v     = sum_v_reg;
    assign out_sigma = sigma_reg;
    assign out_xi    = sum_xi_reg;

endmodule

// ----- rtl/core/supergrid_taper_profile_core.sv -----
// ---------------------------------------------------------------------------
// supergrid_taper_profile_core: absorbing-layer profile per grid point
// Layer depth ratio, C5 smoothstep, stretching, damping and corner taper.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+--------------------------------
//   in      | input     | in_valid / in_stall  | position
//   out     | output    | out_valid / out_stall| stretch, damping, corner_weight
//   cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// One word enters per cycle while in_stall is low.
// The depth is set by two restoring dividers resolving one quotient bit per
// stage (30 and 32 stages) and a ten-stage power chain of rounded multiplies.
// Reset clears valid bits and loads the register defaults; no clearing pass.
// A stall at the output fills a one-word skid stage and then freezes the
// whole pipeline; in_stall is that skid stage's full flag.
// ---------------------------------------------------------------------------
module supergrid_taper_profile_core
    import stpr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [31:0]          position,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [30:0]          stretch,
    output logic [31:0]          damping,
    output logic [30:0]          corner_weight,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    cfg_t        cfg_reg;
    logic        en;

    logic        lay_v;
    xi_mode_t    lay_mode;
    logic [30:0] lay_num;
    logic [30:0] lay_width;

    logic              d1_v;
    logic [XI_QW-1:0]  d1_quo;
    logic [1:0]        d1_side;
    xi_mode_t          d1_mode;
    q30_t              xi;

    logic        poly_v;
    q30_t        poly_sigma;
    q30_t        poly_xi;

    logic        phi_v_reg;
    q30_t        phi_reg;
    q30_t        sigma_reg;
    q30_t        corner_reg;
    logic [32:0] eps_comp;
    logic [63:0] r_prod;
    logic [60:0] c_prod;
    q30_t        phi_next;
    q30_t        corner_next;

    logic        prep_v_reg;
    logic [46:0] dnum_reg;
    dside_t      dside_reg;
    logic [46:0] dnum_next;
    damp_mode_t  dmode_next;

    logic                         d2_v;
    logic [DAMP_QW-1:0]           d2_quo;
    logic [$bits(dside_t)-1:0]    d2_side;
    dside_t                       d2_fin;
    out_word_t                    pipe_word;

    logic        out_valid_reg;
    out_word_t   out_word_reg;
    logic        skid_valid_reg;
    out_word_t   skid_word_reg;
    logic        take;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_enable  <= 1'b0;
            cfg_reg.right_enable <= 1'b0;
            cfg_reg.left_start   <= RST_LEFT_START;
            cfg_reg.right_end    <= RST_RIGHT_END;
            cfg_reg.taper_width  <= RST_TAPER_WIDTH;
            cfg_reg.min_stretch  <= RST_MIN_STRETCH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LEFT_ENABLE:  cfg_reg.left_enable  <= cfg_data[0];
                CFG_RIGHT_ENABLE: cfg_reg.right_enable <= cfg_data[0];
                CFG_LEFT_START:   cfg_reg.left_start   <= cfg_data;
                CFG_RIGHT_END:    cfg_reg.right_end    <= cfg_data;
                CFG_TAPER_WIDTH:  cfg_reg.taper_width  <= cfg_data[30:0];
                CFG_MIN_STRETCH:  cfg_reg.min_stretch  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advances while the skid stage is empty
    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    stpr_layer u_layer (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_v      (in_valid),
        .position  (position),
        .cfg       (cfg_reg),
        .out_v     (lay_v),
        .out_mode  (lay_mode),
        .out_num   (lay_num),
        .out_width (lay_width)
    );

    // Depth ratio num * 2^30 / width
    stpr_div #(
        .QW (XI_QW),
        .DW (XI_DW),
        .SW (2)
    ) u_xi_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_v     (lay_v),
        .in_rem   (lay_num),
        .in_low   ('0),
        .in_div   (lay_width),
        .in_side  (lay_mode),
        .out_v    (d1_v),
        .out_quo  (d1_quo),
        .out_side (d1_side)
    );

    // Resolve the depth
    always_comb
    begin
        d1_mode = xi_mode_t'(d1_side);
        case (d1_mode)
            XI_ZERO: xi = '0;
            XI_ONE:  xi = ONE_Q30;
            XI_DIV:  xi = {1'b0, d1_quo};
            default: xi = '0;
        endcase
    end

    stpr_poly u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_v      (d1_v),
        .in_t      (xi),
        .out_v     (poly_v),
        .out_sigma (poly_sigma),
        .out_xi    (poly_xi)
    );

    // Stretching and corner taper
    always_comb
    begin
        eps_comp    = 33'h1_0000_0000 - {1'b0, cfg_reg.min_stretch};
        r_prod      = 64'(poly_sigma) * 64'(eps_comp) + 64'h8000_0000;
        phi_next    = ONE_Q30 - r_prod[62:32];
        c_prod      = 61'(CORNER_SLOPE) * 61'(poly_xi) + 61'(HALF_Q30);
        corner_next = ONE_Q30 - c_prod[60:30];
    end

    // Damping numerator and its special cases
    always_comb
    begin
        dnum_next = {sigma_reg, 16'h0000} + 47'(phi_reg >> 1);
        if (sigma_reg == '0)
            dmode_next = DAMP_ZERO;
        else if (phi_reg == '0)
            dmode_next = DAMP_MAX;
        else if ({16'h0000, dnum_next[46:32]} >= phi_reg)
            dmode_next = DAMP_MAX;
        else
            dmode_next = DAMP_DIV;
    end

    // Advance valid bits of the middle stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phi_v_reg  <= 1'b0;
            prep_v_reg <= 1'b0;
        end
        else if (en)
        begin
            phi_v_reg  <= poly_v;
            prep_v_reg <= phi_v_reg;
        end
    end

    // Advance payload of the middle stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phi_reg          <= phi_next;
            sigma_reg        <= poly_sigma;
            corner_reg       <= corner_next;
            dnum_reg         <= dnum_next;
            dside_reg.mode   <= dmode_next;
            dside_reg.phi    <= phi_reg;
            dside_reg.corner <= corner_reg;
        end
    end

    // Damping ratio sigma / phi
    stpr_div #(
        .QW (DAMP_QW),
        .DW (DAMP_DW),
        .SW ($bits(dside_t))
    ) u_damp_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_v     (prep_v_reg),
        .in_rem   ({16'h0000, dnum_reg[46:32]}),
        .in_low   (dnum_reg[31:0]),
        .in_div   (dside_reg.phi),
        .in_side  (dside_reg),
        .out_v    (d2_v),
        .out_quo  (d2_quo),
        .out_side (d2_side)
    );

    // Assemble the result word
    always_comb
    begin
        d2_fin                  = dside_t'(d2_side);
        pipe_word.stretch       = d2_fin.phi;
        pipe_word.corner_weight = d2_fin.corner;
        case (d2_fin.mode)
            DAMP_ZERO: pipe_word.damping = '0;
            DAMP_MAX:  pipe_word.damping = '1;
            DAMP_DIV:  pipe_word.damping = d2_quo;
            default:   pipe_word.damping = '0;
        endcase
    end

    assign take = out_valid_reg && !out_stall;

    // Output register and skid stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= d2_v;
        end
        else if (d2_v && en)
            skid_valid_reg <= 1'b1;
    end

    // Output register and skid stage payload
    always_ff @(posedge clk)
    begin
        if (take || !out_valid_reg)
        begin
            if (skid_valid_reg)
                out_word_reg <= skid_word_reg;
            else
                out_word_reg <= pipe_word;
        end
        else if (en)
            skid_word_reg <= pipe_word;
    end

    assign out_valid     = out_valid_reg;
    assign stretch       = out_word_reg.stretch;
    assign damping       = out_word_reg.damping;
    assign corner_weight = out_word_reg.corner_weight;

    // Skid stage only fills behind a held output word
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word present without an output word");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid stage filled while output was free");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_stall) |=> !skid_valid_reg)
        else $error("skid word not moved on after output taken");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (stretch <= ONE_Q30) && (corner_weight <= ONE_Q30))
        else $error("profile value above one");

endmodule

// ----- bench/tb_supergrid_taper_profile_core.sv -----
// ---------------------------------------------------------------------------
// tb_supergrid_taper_profile_core: self-checking bench of the taper profile
// Drives grid positions through the core under several layer settings and
// compares each result word with a bit-exact profile predictor held here.
// ---------------------------------------------------------------------------
module tb_supergrid_taper_profile_core;
    import stpr_pkg::*;

    localparam int  WATCHDOG_LIMIT = 4000;
    localparam int  DRAIN_CYCLES   = 100;
    localparam int  HOLD_CYCLES    = 400;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 3'd7;
    localparam logic [63:0] ONE30  = 64'd1 << 30;
    localparam logic [63:0] HALF30 = 64'd1 << 29;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [31:0]          position = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [30:0]          stretch;
    logic [31:0]          damping;
    logic [30:0]          corner_weight;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    // Predictor copy of the layer settings
    logic        lyr_left_en;
    logic        lyr_right_en;
    logic [31:0] lyr_left_start;
    logic [31:0] lyr_right_end;
    logic [30:0] lyr_width;
    logic [31:0] lyr_eps;

    out_word_t profile_q[$];
    int        fail_count = 0;
    int        burst_left = 0;
    int        idle_cycles = 0;
    logic      hold_req = 1'b0;
    logic      hold_ack = 1'b0;
    int        hold_cnt = 0;
    int        stall_mode = 0;
    int        stall_timer = 0;

    always #1 clk = ~clk;

    supergrid_taper_profile_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .position      (position),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .stretch       (stretch),
        .damping       (damping),
        .corner_weight (corner_weight),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Rounded Q30 product
    function automatic logic [63:0] q30_mul(logic [63:0] a, logic [63:0] b);
        return (a * b + HALF30) >> 30;
    endfunction

    function automatic logic [63:0] depth_ratio(longint num, logic [63:0] w);
        if (num <= 0)
            return 0;
        if (64'(num) >= w)
            return ONE30;
        return (64'(num) << 30) / w;
    endfunction

    // C5 smoothstep in Bernstein form
    function automatic logic [63:0] smoothstep_c5(logic [63:0] t);
        logic [63:0] tp[12];
        logic [63:0] up[12];
        logic [63:0] acc;
        logic [63:0] u;
        logic [63:0] coef[12];
        coef = '{1, 11, 55, 165, 330, 462, 462, 330, 165, 55, 11, 1};
        acc = 0;
        u = ONE30 - t;
        tp[0] = ONE30;
        up[0] = ONE30;
        for (int k = 1; k < 12; k++)
        begin
            tp[k] = q30_mul(tp[k-1], t);
            up[k] = q30_mul(up[k-1], u);
        end
        for (int k = 6; k < 12; k++)
            acc += coef[k] * q30_mul(tp[k], up[11-k]);
        return (acc > ONE30) ? ONE30 : acc;
    endfunction

    function automatic out_word_t profile_at(logic [31:0] x_raw);
        longint      x;
        longint      x0;
        longint      x1;
        longint      w;
        logic [63:0] xi;
        logic [63:0] sigma;
        logic [63:0] phi;
        logic [63:0] damp;
        out_word_t   res;
        x  = longint'(signed'(x_raw));
        x0 = longint'(signed'(lyr_left_start));
        x1 = longint'(signed'(lyr_right_end));
        w  = longint'(lyr_width);
        xi = 0;
        // left layer wins where both apply
        if (lyr_left_en && x < x0 + w)
            xi = depth_ratio(x0 + w - x, 64'(w));
        else if (lyr_right_en && x > x1 - w)
            xi = depth_ratio(x - (x1 - w), 64'(w));
        sigma = smoothstep_c5(xi);
        phi = ONE30 - ((sigma * ((64'd1 << 32) - 64'(lyr_eps)) + (64'd1 << 31)) >> 32);
        if (sigma == 0)
            damp = 0;
        else if (phi == 0)
            damp = 64'hFFFF_FFFF;
        else
        begin
            damp = ((sigma << 16) + (phi >> 1)) / phi;
            if (damp > 64'hFFFF_FFFF)
                damp = 64'hFFFF_FFFF;
        end
        res.stretch       = phi[30:0];
        res.damping       = damp[31:0];
        res.corner_weight = 31'(ONE30 - ((64'(CORNER_SLOPE) * xi + HALF30) >> 30));
        return res;
    endfunction

    // Hold the write strobe up; set_layers drops it
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_LEFT_ENABLE:  lyr_left_en    = data[0];
            CFG_RIGHT_ENABLE: lyr_right_en   = data[0];
            CFG_LEFT_START:   lyr_left_start = data;
            CFG_RIGHT_END:    lyr_right_end  = data;
            CFG_TAPER_WIDTH:  lyr_width      = data[30:0];
            CFG_MIN_STRETCH:  lyr_eps        = data;
            default: ;
        endcase
    endtask

    task automatic set_layers(input logic le, input logic re, input logic [31:0] x0,
                              input logic [31:0] x1, input logic [31:0] w,
                              input logic [31:0] eps);
        cfg_write(CFG_LEFT_ENABLE, {31'd0, le});
        cfg_write(CFG_RIGHT_ENABLE, {31'd0, re});
        cfg_write(CFG_LEFT_START, x0);
        cfg_write(CFG_RIGHT_END, x1);
        cfg_write(CFG_TAPER_WIDTH, w);
        cfg_write(CFG_MIN_STRETCH, eps);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Stop sending and let the pipeline empty
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (profile_q.size() > 0)
            @(posedge clk);
        repeat (90) @(posedge clk);
    endtask

    task automatic send_position(input logic [31:0] x);
        in_valid <= 1'b1;
        position <= x;
        do
            @(posedge clk);
        while (in_stall);
        profile_q.push_back(profile_at(x));
    endtask

    // Bursty sender: drop valid for a random gap between bursts
    task automatic send_bursty(input logic [31:0] x);
        int gap;
        send_position(x);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 40);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Positions mostly in or near the layers, some anywhere
    function automatic logic [31:0] pick_position();
        longint w;
        longint off;
        w = longint'(lyr_width);
        off = longint'({$urandom, $urandom} % 64'(3 * w + 5)) - w - 2;
        case ($urandom_range(0, 5))
            0, 1:    return 32'(longint'(signed'(lyr_left_start)) + off);
            2, 3:    return 32'(longint'(signed'(lyr_right_end)) - off);
            4:       return $urandom;
            default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_position(32'h0000_0000);
        send_position(32'h7FFF_FFFF);
        send_position(32'h8000_0000);
        send_position(32'h0001_0000);
        wait_idle();
    endtask

    task automatic test_both_layers();
        cfg_write(CFG_UNUSED_A, 32'hFFFF_FFFF);
        cfg_write(CFG_UNUSED_B, 32'h1234_5678);
        set_layers(1'b1, 1'b1, 32'd0, 32'd65536, 32'd6554, 32'd429497);
        send_position(32'd0);
        send_position(32'd3277);
        send_position(32'd6554);
        send_position(32'd65536 - 32'd3277);
        send_position(32'd65536);
        send_position(-32'sd100000);
        send_position(32'd200000);
        send_position(32'd30000);
        wait_idle();
    endtask

    task automatic test_overlap_and_extremes();
        // left layer covers x < -1 and right layer x > 0; widest taper and largest eps
        set_layers(1'b1, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_position(32'h8000_0000);
        send_position(32'h0000_0000);
        send_position(32'h7FFF_FFFF);
        wait_idle();
        // zero eps: stretch reaches zero and damping saturates
        set_layers(1'b0, 1'b1, 32'd0, 32'd65536, 32'd6554, 32'd0);
        send_position(32'd65536);
        send_position(32'd62000);
        wait_idle();
        // zero width: any point in the layer is at full depth
        set_layers(1'b1, 1'b1, 32'd100, 32'd200, 32'd0, 32'd1000);
        send_position(32'd99);
        send_position(32'd100);
        send_position(32'd201);
        send_position(32'd150);
        wait_idle();
    endtask

    task automatic test_random_profiles();
        logic [31:0] w;
        logic [31:0] eps;
        for (int ph = 0; ph < 9; ph++)
        begin
            case ($urandom_range(0, 9))
                0:       w = 32'h7FFF_FFFF;
                1:       w = 32'd0;
                2:       w = $urandom & 32'h7FFF_FFFF;
                default: w = $urandom_range(1, 1 << 20);
            endcase
            case ($urandom_range(0, 5))
                0:       eps = 32'd0;
                1:       eps = 32'hFFFF_FFFF;
                default: eps = $urandom;
            endcase
            set_layers($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                       $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 20),
                       $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1 << 21, 1 << 23),
                       w, eps);
            for (int i = 0; i < 190; i++)
                send_bursty(pick_position());
            wait_idle();
        end
    endtask

    task automatic test_backpressure();
        set_layers(1'b1, 1'b1, 32'd0, 32'd655360, 32'd65536, $urandom);
        hold_req = ~hold_req;
        for (int i = 0; i < 150; i++)
            send_position(pick_position());
        wait_idle();
    endtask

    // Receiver stall pattern, with an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack <= hold_req;
            hold_cnt <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            if (stall_timer == 0)
            begin
                stall_mode  <= $urandom_range(0, 3);
                stall_timer <= $urandom_range(50, 300);
            end
            else
                stall_timer <= stall_timer - 1;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= stall_timer[4];
            endcase
        end
    end

    // Compare each result word with the oldest prediction
    always @(posedge clk)
    begin
        out_word_t exp_w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (profile_q.size() == 0)
            begin
                $error("result word with no prediction waiting");
                fail_count++;
            end
            else
            begin
                exp_w = profile_q.pop_front();
                if (stretch !== exp_w.stretch)
                begin
                    $error("stretch: expected %0d, got %0d", exp_w.stretch, stretch);
                    fail_count++;
                end
                if (damping !== exp_w.damping)
                begin
                    $error("damping: expected %0d, got %0d", exp_w.damping, damping);
                    fail_count++;
                end
                if (corner_weight !== exp_w.corner_weight)
                begin
                    $error("corner_weight: expected %0d, got %0d",
                           exp_w.corner_weight, corner_weight);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no traffic at all
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("supergrid_taper_profile_core test failed");
            $finish;
        end
    end

    initial
    begin
        lyr_left_en    = 1'b0;
        lyr_right_en   = 1'b0;
        lyr_left_start = RST_LEFT_START;
        lyr_right_end  = RST_RIGHT_END;
        lyr_width      = RST_TAPER_WIDTH;
        lyr_eps        = RST_MIN_STRETCH;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_both_layers();
        test_overlap_and_extremes();
        test_backpressure();
        test_random_profiles();
        in_valid <= 1'b0;
        while (profile_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("supergrid_taper_profile_core test passed");
        else
            $display("supergrid_taper_profile_core test failed");
        $finish;
    end

endmodule
